// File: rtl/ifk_pkg.sv
// Package for the IP flow key extractor: field widths, protocol codes,
// header offsets and the result record type. No dependencies.
package ifk_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PortW = 16;
  localparam int unsigned AddrW = 64;
  localparam int unsigned PosW  = 7;
  localparam int unsigned OffW  = 6;

  localparam logic [7:0] PROTO_TCP = 8'h06;
  localparam logic [7:0] PROTO_UDP = 8'h11;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [3:0] VER_IPV4    = 4'd4;
  localparam logic [3:0] VER_IPV6    = 4'd6;

  localparam logic [OffW-1:0] V6_HEADER_LEN = 6'd40;

  localparam logic [PosW-1:0] POS_MAX      = 7'd127;
  localparam logic [PosW-1:0] V4_PROTO_POS = 7'd9;
  localparam logic [PosW-1:0] V6_PROTO_POS = 7'd6;
  localparam logic [PosW-1:0] V4_SRC_FIRST = 7'd12;
  localparam logic [PosW-1:0] V4_SRC_LAST  = 7'd15;
  localparam logic [PosW-1:0] V4_DST_FIRST = 7'd16;
  localparam logic [PosW-1:0] V4_DST_LAST  = 7'd19;
  localparam logic [PosW-1:0] V6_SRC_FIRST = 7'd8;
  localparam logic [PosW-1:0] V6_SRC_MID   = 7'd16;
  localparam logic [PosW-1:0] V6_DST_FIRST = 7'd24;
  localparam logic [PosW-1:0] V6_DST_MID   = 7'd32;
  localparam logic [PosW-1:0] V6_DST_LAST  = 7'd39;
  localparam logic [PosW-1:0] V4_NEED_END  = 7'd19;
  localparam logic [PosW-1:0] V6_NEED_END  = 7'd39;

  typedef enum logic [1:0] {
    NET_UNKNOWN = 2'd0,
    NET_IPV4    = 2'd1,
    NET_IPV6    = 2'd2
  } net_kind_t;

  typedef enum logic [1:0] {
    TR_UNKNOWN = 2'd0,
    TR_TCP     = 2'd1,
    TR_UDP     = 2'd2
  } tr_kind_t;

  typedef struct packed {
    net_kind_t          network_kind;
    tr_kind_t           transport_kind;
    logic [AddrW-1:0]   source_addr_high;
    logic [AddrW-1:0]   source_addr_low;
    logic [AddrW-1:0]   dest_addr_high;
    logic [AddrW-1:0]   dest_addr_low;
    logic [PortW-1:0]   source_port;
    logic [PortW-1:0]   dest_port;
    logic               truncated;
  } key_t;

endpackage

// File: rtl/ifk_channels.sv
// Valid/ready channel interfaces for the flow key extractor: packet bytes in,
// flow keys out. Depends on ifk_pkg for field widths.
interface ifk_byte_if import ifk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface ifk_key_if import ifk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       network_kind;
  logic [1:0]       transport_kind;
  logic [AddrW-1:0] source_addr_high;
  logic [AddrW-1:0] source_addr_low;
  logic [AddrW-1:0] dest_addr_high;
  logic [AddrW-1:0] dest_addr_low;
  logic [PortW-1:0] source_port;
  logic [PortW-1:0] dest_port;
  logic             truncated;

  modport source (output valid, output network_kind, output transport_kind,
                  output source_addr_high, output source_addr_low,
                  output dest_addr_high, output dest_addr_low,
                  output source_port, output dest_port, output truncated,
                  input ready);
  modport sink   (input valid, input network_kind, input transport_kind,
                  input source_addr_high, input source_addr_low,
                  input dest_addr_high, input dest_addr_low,
                  input source_port, input dest_port, input truncated,
                  output ready);
endinterface

// File: rtl/ip_flow_key_extractor.sv
// A flow key reaches key_out through the input register, which takes its last byte
// when the request is accepted, and then the result queue, which the parse logic writes
// from that register with no stall in between.
// Throughput: one byte per cycle; the result queue of RESULT_DEPTH entries lets
// bytes keep flowing while finished keys wait, and byte_in stalls only when the queue,
// counting a last byte still held in the input register, is full.
// Reset (synchronous, rst high) empties the queue and the input register and
// clears all per-packet parse state; the next byte is taken as IP header byte 0.
module ip_flow_key_extractor
  import ifk_pkg::*;
#(
  parameter int unsigned RESULT_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  ifk_byte_if.sink   byte_in,
  ifk_key_if.source  key_out
);

  localparam int unsigned PtrW = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RESULT_DEPTH + 1);

  // Input register
  logic             s_valid;
  logic [ByteW-1:0] s_byte;
  logic             s_last;

  // Per-packet parse state
  logic [PosW-1:0]  byte_position, byte_position_next;
  logic [3:0]       ip_version_seen, ip_version_seen_next;
  logic [OffW-1:0]  payload_offset, payload_offset_next;
  logic [ByteW-1:0] next_protocol, next_protocol_next;
  logic [AddrW-1:0] src_hi, src_hi_next, src_lo, src_lo_next;
  logic [AddrW-1:0] dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic [PortW-1:0] first_port, first_port_next;
  logic [PortW-1:0] second_port, second_port_next;

  // Result queue
  key_t             res_mem [RESULT_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  key_t             result;
  key_t             head;

  logic             accept, push, pop;
  logic [CntW:0]    reserved;

  function automatic logic [AddrW-1:0] put_byte(input logic [AddrW-1:0] word,
                                                input logic [2:0] slot,
                                                input logic [ByteW-1:0] b);
    logic [AddrW-1:0] w;
    w = word;
    for (int i = 0; i < 8; i++) begin
      if (slot == 3'(i)) w[AddrW-1-8*i -: 8] = b;
    end
    return w;
  endfunction

  // A last byte waiting in the input register already holds a queue slot.
  assign reserved      = (CntW+1)'(count) + (CntW+1)'(s_valid & s_last);
  assign byte_in.ready = reserved < (CntW+1)'(RESULT_DEPTH);
  assign accept        = byte_in.valid & byte_in.ready;
  assign push          = s_valid & s_last;
  assign pop           = key_out.valid & key_out.ready;

  always_comb begin
    logic [3:0]      ver;
    logic [OffW-1:0] off;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] off7;
    logic [PosW-1:0] need_end;
    logic            v4, v6;
    tr_kind_t        tr;

    pos = byte_position;
    if (pos == '0) begin
      ver = (s_byte[7:4] & NIBBLE_MASK);
      if (ver == VER_IPV4)      off = {s_byte[3:0], 2'b00};
      else if (ver == VER_IPV6) off = V6_HEADER_LEN;
      else                      off = '0;
    end else begin
      ver = ip_version_seen;
      off = payload_offset;
    end
    v4   = (ver == VER_IPV4);
    v6   = (ver == VER_IPV6);
    off7 = {1'b0, off};

    ip_version_seen_next = ver;
    payload_offset_next  = off;
    next_protocol_next   = next_protocol;
    src_hi_next          = src_hi;
    src_lo_next          = src_lo;
    dst_hi_next          = dst_hi;
    dst_lo_next          = dst_lo;
    first_port_next      = first_port;
    second_port_next     = second_port;

    if (v4) begin
      if (pos == V4_PROTO_POS) next_protocol_next = s_byte;
      if (pos >= V4_SRC_FIRST && pos <= V4_SRC_LAST)
        src_lo_next = put_byte(src_lo, pos[2:0], s_byte);
      if (pos >= V4_DST_FIRST && pos <= V4_DST_LAST)
        dst_lo_next = put_byte(dst_lo, pos[2:0] + 3'd4, s_byte);
    end else if (v6) begin
      if (pos == V6_PROTO_POS) next_protocol_next = s_byte;
      if (pos >= V6_SRC_FIRST && pos < V6_SRC_MID)
        src_hi_next = put_byte(src_hi, pos[2:0], s_byte);
      if (pos >= V6_SRC_MID && pos < V6_DST_FIRST)
        src_lo_next = put_byte(src_lo, pos[2:0], s_byte);
      if (pos >= V6_DST_FIRST && pos < V6_DST_MID)
        dst_hi_next = put_byte(dst_hi, pos[2:0], s_byte);
      if (pos >= V6_DST_MID && pos <= V6_DST_LAST)
        dst_lo_next = put_byte(dst_lo, pos[2:0], s_byte);
    end

    if (v4 || v6) begin
      if (pos == off7)         first_port_next  = {s_byte, 8'h00};
      if (pos == off7 + 7'd1)  first_port_next  = first_port_next | {8'h00, s_byte};
      if (pos == off7 + 7'd2)  second_port_next = {s_byte, 8'h00};
      if (pos == off7 + 7'd3)  second_port_next = second_port_next | {8'h00, s_byte};
    end

    byte_position_next = (pos == POS_MAX) ? pos : pos + 7'd1;

    if (next_protocol_next == PROTO_TCP)      tr = TR_TCP;
    else if (next_protocol_next == PROTO_UDP) tr = TR_UDP;
    else                                      tr = TR_UNKNOWN;

    need_end = v4 ? V4_NEED_END : V6_NEED_END;
    if (tr != TR_UNKNOWN && (off7 + 7'd3) > need_end) need_end = off7 + 7'd3;

    result = '0;
    if (v4 || v6) begin
      result.network_kind     = v4 ? NET_IPV4 : NET_IPV6;
      result.transport_kind   = tr;
      result.source_addr_high = src_hi_next;
      result.source_addr_low  = src_lo_next;
      result.dest_addr_high   = dst_hi_next;
      result.dest_addr_low    = dst_lo_next;
      result.source_port      = (tr != TR_UNKNOWN) ? first_port_next : '0;
      result.dest_port        = (tr != TR_UNKNOWN) ? second_port_next : '0;
      result.truncated        = (pos < need_end);
    end

    // The last byte of a packet starts the next packet from a clean slate.
    if (s_last) begin
      byte_position_next   = '0;
      ip_version_seen_next = '0;
      payload_offset_next  = '0;
      next_protocol_next   = '0;
      src_hi_next          = '0;
      src_lo_next          = '0;
      dst_hi_next          = '0;
      dst_lo_next          = '0;
      first_port_next      = '0;
      second_port_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
    if (accept) begin
      s_byte <= byte_in.packet_byte;
      s_last <= byte_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      ip_version_seen <= '0;
      payload_offset  <= '0;
      next_protocol   <= '0;
      src_hi          <= '0;
      src_lo          <= '0;
      dst_hi          <= '0;
      dst_lo          <= '0;
      first_port      <= '0;
      second_port     <= '0;
    end else if (s_valid) begin
      byte_position   <= byte_position_next;
      ip_version_seen <= ip_version_seen_next;
      payload_offset  <= payload_offset_next;
      next_protocol   <= next_protocol_next;
      src_hi          <= src_hi_next;
      src_lo          <= src_lo_next;
      dst_hi          <= dst_hi_next;
      dst_lo          <= dst_lo_next;
      first_port      <= first_port_next;
      second_port     <= second_port_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_mem[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(RESULT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(RESULT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = res_mem[rd_ptr];

  assign key_out.valid            = (count != '0);
  assign key_out.network_kind     = head.network_kind;
  assign key_out.transport_kind   = head.transport_kind;
  assign key_out.source_addr_high = head.source_addr_high;
  assign key_out.source_addr_low  = head.source_addr_low;
  assign key_out.dest_addr_high   = head.dest_addr_high;
  assign key_out.dest_addr_low    = head.dest_addr_low;
  assign key_out.source_port      = head.source_port;
  assign key_out.dest_port        = head.dest_port;
  assign key_out.truncated        = head.truncated;

endmodule

// File: rtl/ifk_checker.sv
// Port-level checks for the flow key extractor, attached by the bind below.
// Depends on ifk_pkg for widths and kind codes.
module ifk_checker
  import ifk_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       network_kind,
  input logic [1:0]       transport_kind,
  input logic [AddrW-1:0] source_addr_high,
  input logic [AddrW-1:0] dest_addr_high,
  input logic [PortW-1:0] source_port,
  input logic [PortW-1:0] dest_port,
  input logic             truncated
);

  // A stalled key request keeps its kinds, ports and truncated flag.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(network_kind) &&
      $stable(transport_kind) && $stable(source_port) && $stable(dest_port) &&
      $stable(truncated))
    else $error("flow key changed while stalled");

  // Nothing is left over in the queue after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("flow key valid right after reset");

  a_unknown_net: assert property (@(posedge clk) disable iff (rst)
    out_valid && network_kind == NET_UNKNOWN |->
      transport_kind == TR_UNKNOWN && !truncated && source_port == '0 &&
      dest_port == '0)
    else $error("unknown network type with nonzero fields");

  a_v4_high_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && network_kind == NET_IPV4 |->
      source_addr_high == '0 && dest_addr_high == '0)
    else $error("IPv4 key with upper address bits set");

  a_ports_need_transport: assert property (@(posedge clk) disable iff (rst)
    out_valid && transport_kind == TR_UNKNOWN |-> source_port == '0 && dest_port == '0)
    else $error("ports reported without TCP or UDP");

endmodule

bind ip_flow_key_extractor ifk_checker u_ifk_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (key_out.valid),
  .out_ready        (key_out.ready),
  .network_kind     (key_out.network_kind),
  .transport_kind   (key_out.transport_kind),
  .source_addr_high (key_out.source_addr_high),
  .dest_addr_high   (key_out.dest_addr_high),
  .source_port      (key_out.source_port),
  .dest_port        (key_out.dest_port),
  .truncated        (key_out.truncated)
);
